### rtl/bfhs_pkg.sv
// Shared types and defaults for the back/forward history stack.
// Transaction structs, op and status codes, storage size defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfhs_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int LOCATION_BITS_DEF = 64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_BACK = 2'd1,
    OP_FWD  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NONE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] location;
    logic        location_ok;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] found_location;
  } out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage : bfhs_pkg

`default_nettype wire

### rtl/bfhs_ctrl.sv
// Cursor, entry count and ring pointer of the history, with the
// per-transaction update logic and store address generation. Uses bfhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfhs_ctrl #(
  parameter int HISTORY_DEPTH = bfhs_pkg::HISTORY_DEPTH_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH),
  localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           op_i,
  input  wire logic                 location_ok_i,
  output bfhs_pkg::store_ctl_t      store_ctl_o,
  output logic [AW-1:0]             waddr_o,
  output logic [AW-1:0]             raddr_o,
  output bfhs_pkg::status_e         status_o,
  output logic                      found_sel_o
);

  localparam logic [AW:0]   DepthW = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DepthM1C = CW'(HISTORY_DEPTH - 1);
  localparam logic [AW-1:0] OneA = AW'(1);

  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cursor_q, cursor_d;

  logic [CW-1:0] cur_p1;
  logic [CW-1:0] cnt_trim;
  logic [CW-1:0] cnt_push;
  logic          full;
  logic [AW-1:0] oldest_push;

  always_comb begin
    cur_p1      = CW'(cursor_q) + CW'(1);
    cnt_trim    = (count_q != '0 && cur_p1 < count_q) ? cur_p1 : count_q;
    full        = (cnt_trim == DepthC);
    cnt_push    = full ? DepthM1C : cnt_trim;
    oldest_push = full ? ring_slot(oldest_q, OneA) : oldest_q;

    oldest_d    = oldest_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    store_ctl_o = '0;
    waddr_o     = ring_slot(oldest_push, cnt_push[AW-1:0]);
    raddr_o     = '0;
    status_o    = bfhs_pkg::ST_OK;
    found_sel_o = 1'b0;

    case (op_i)
      bfhs_pkg::OP_PUSH: begin
        if (!location_ok_i) begin
          status_o = bfhs_pkg::ST_INVALID;
        end else begin
          store_ctl_o.wr_en = accept_i;
          oldest_d          = oldest_push;
          count_d           = cnt_push + CW'(1);
          cursor_d          = cnt_push[AW-1:0];
        end
      end
      bfhs_pkg::OP_BACK: begin
        raddr_o = ring_slot(oldest_q, cursor_q - OneA);
        if (count_q == '0 || cursor_q == '0) begin
          status_o = bfhs_pkg::ST_NONE;
        end else begin
          store_ctl_o.rd_en = accept_i;
          found_sel_o       = 1'b1;
          cursor_d          = cursor_q - OneA;
        end
      end
      bfhs_pkg::OP_FWD: begin
        raddr_o = ring_slot(oldest_q, cursor_q + OneA);
        if (count_q == '0 || cur_p1 >= count_q) begin
          status_o = bfhs_pkg::ST_NONE;
        end else begin
          store_ctl_o.rd_en = accept_i;
          found_sel_o       = 1'b1;
          cursor_d          = cursor_q + OneA;
        end
      end
      default: begin
        status_o = bfhs_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
      cursor_q <= '0;
    end else if (accept_i) begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

endmodule : bfhs_ctrl

`default_nettype wire

### rtl/bfhs_store.sv
// Ring store of location words: one write port, one registered read port.
// Uses bfhs_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module bfhs_store #(
  parameter int HISTORY_DEPTH = bfhs_pkg::HISTORY_DEPTH_DEF,
  parameter int LOCATION_BITS = bfhs_pkg::LOCATION_BITS_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire bfhs_pkg::store_ctl_t     store_ctl_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [LOCATION_BITS-1:0] wdata_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic [LOCATION_BITS-1:0]      rdata_o
);

  logic [LOCATION_BITS-1:0] mem [HISTORY_DEPTH];
  logic [LOCATION_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (store_ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (store_ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : bfhs_store

`default_nettype wire

### rtl/back_forward_history_stack.sv
// Top level of the back/forward history stack: controller, ring store and
// result register. Uses bfhs_pkg, bfhs_ctrl, bfhs_store.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one bfhs_pkg::in_t per
//   transaction: push (op 0), back (op 1) or forward (op 2). Output channel
//   out_valid_o / out_ready_i returns exactly one bfhs_pkg::out_t per input.
//   The result of a transaction is registered when it is accepted and is
//   valid in the next cycle. Throughput is one transaction per cycle while
//   the output is not stalled; the state update and any store access (a
//   write on a valid push, a registered read on a hit) fit in that cycle.
//   While a result waits and out_ready_i is low, in_ready_o drops and the
//   result holds; when out_ready_i is high a new input is taken in the same
//   cycle the result leaves.
//   Reset empties the history (count, cursor and ring pointer to zero);
//   the store itself is not cleared and needs no sweep, so the block is
//   ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module back_forward_history_stack #(
  parameter int HISTORY_DEPTH = bfhs_pkg::HISTORY_DEPTH_DEF,
  parameter int LOCATION_BITS = bfhs_pkg::LOCATION_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bfhs_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bfhs_pkg::out_t     out_data_o
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic                     accept;
  bfhs_pkg::store_ctl_t     store_ctl;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  bfhs_pkg::status_e        status;
  logic                     found_sel;
  logic [LOCATION_BITS-1:0] rdata;

  logic                     out_valid_q;
  bfhs_pkg::status_e        status_q;
  logic                     found_sel_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  bfhs_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (in_data_i.op),
    .location_ok_i(in_data_i.location_ok),
    .store_ctl_o  (store_ctl),
    .waddr_o      (waddr),
    .raddr_o      (raddr),
    .status_o     (status),
    .found_sel_o  (found_sel)
  );

  bfhs_store #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .LOCATION_BITS(LOCATION_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .store_ctl_i(store_ctl),
    .waddr_i    (waddr),
    .wdata_i    (in_data_i.location[LOCATION_BITS-1:0]),
    .raddr_i    (raddr),
    .rdata_o    (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status;
      found_sel_q <= found_sel;
    end
  end

  assign out_valid_o               = out_valid_q;
  assign out_data_o.status         = status_q;
  assign out_data_o.found_location = found_sel_q ? 64'(rdata) : 64'd0;

endmodule : back_forward_history_stack

`default_nettype wire

### rtl/bfhs_checker.sv
// Port-level checks for back_forward_history_stack, with its bind.
// Uses bfhs_pkg codes.
`timescale 1ns / 1ps
`default_nettype none

module bfhs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire bfhs_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire bfhs_pkg::out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("no result one cycle after input transaction");

  a_bad_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == bfhs_pkg::OP_PUSH && !in_data_i.location_ok
    |=> out_data_o.status == bfhs_pkg::ST_INVALID && out_data_o.found_location == 64'd0)
    else $error("rejected push did not report invalid argument");

  a_good_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == bfhs_pkg::OP_PUSH && in_data_i.location_ok
    |=> out_data_o.status == bfhs_pkg::ST_OK && out_data_o.found_location == 64'd0)
    else $error("accepted push did not report ok with zero location");

endmodule : bfhs_checker

bind back_forward_history_stack bfhs_checker u_bfhs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
